// File: hw/rtl/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared widths, codes and types of the sorted set merge engine.
// ----------------------------------------------------------------------------
package ssm_pkg;

  localparam int LIST_DEPTH  = 32;
  localparam int ADDR_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int LEN_W       = $clog2(LIST_DEPTH + 1);

  localparam int ELEM_W      = 32;
  localparam int MODE_W      = 3;
  localparam int KIND_W      = 2;
  localparam int COUNT_W     = 6;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_INTERSECT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_COUNT     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DIFF      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SPLIT     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_UNION     = 3'd4;

  localparam logic [KIND_W-1:0] KIND_COMMON = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UNION  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_COUNT  = 2'd3;

  typedef struct packed {
    logic                     append;
    logic                     sel;
    logic signed [ELEM_W-1:0] elem;
    logic                     merge;
    logic [MODE_W-1:0]        mode;
  } cmd_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] value;
    logic [KIND_W-1:0]        kind;
    logic                     valid_res;
    logic [COUNT_W-1:0]       match_count;
    logic                     overflow;
    logic                     final_res;
  } res_t;

endpackage

// File: hw/rtl/ssm_if.sv
// ----------------------------------------------------------------------------
// ssm_if
// Valid/ready channels of the sorted set merge engine: load items and results.
// ----------------------------------------------------------------------------
interface ssm_in_if;
  logic                             valid;
  logic                             ready;
  logic [ssm_pkg::MODE_W-1:0]       mode;
  logic                             list_select;
  logic                             has_element;
  logic signed [ssm_pkg::ELEM_W-1:0] element;
  logic                             end_of_load;

  modport source (output valid, output mode, output list_select, output has_element,
                  output element, output end_of_load, input ready);
  modport sink   (input valid, input mode, input list_select, input has_element,
                  input element, input end_of_load, output ready);
endinterface

interface ssm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ssm_pkg::ELEM_W-1:0] value;
  logic [ssm_pkg::KIND_W-1:0]        kind;
  logic                              valid_res;
  logic [ssm_pkg::COUNT_W-1:0]       match_count;
  logic                              overflow;
  logic                              final_res;

  modport source (output valid, output value, output kind, output valid_res,
                  output match_count, output overflow, output final_res, input ready);
  modport sink   (input valid, input value, input kind, input valid_res,
                  input match_count, input overflow, input final_res, output ready);
endinterface

// File: hw/rtl/ssm_ram.sv
// ----------------------------------------------------------------------------
// ssm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/ssm_front.sv
// ----------------------------------------------------------------------------
// ssm_front
// Accepts load items, classifies them into append and merge commands and
// queues the commands for the back end.
// ----------------------------------------------------------------------------
module ssm_front (
  input  logic          clk,
  input  logic          rst_n,
  ssm_in_if.sink        in_ch,
  output logic          cmd_valid,
  output ssm_pkg::cmd_t cmd,
  input  logic          cmd_pop
);

  ssm_pkg::cmd_t               queue_r [ssm_pkg::QUEUE_DEPTH];
  logic [ssm_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [ssm_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [ssm_pkg::QCNT_W-1:0]  count_r, count_nxt;
  ssm_pkg::cmd_t               new_cmd;
  logic                        push;
  logic                        pop;

  assign in_ch.ready = (count_r != ssm_pkg::QCNT_W'(ssm_pkg::QUEUE_DEPTH));

  always_comb begin
    new_cmd.append = in_ch.has_element;
    new_cmd.sel    = in_ch.list_select;
    new_cmd.elem   = in_ch.element;
    new_cmd.merge  = in_ch.end_of_load;
    new_cmd.mode   = in_ch.mode;
  end

  // drop items that neither append nor merge
  assign push = in_ch.valid && in_ch.ready && (in_ch.has_element || in_ch.end_of_load);
  assign pop  = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + ssm_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + ssm_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + ssm_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - ssm_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= new_cmd;
    end
  end

  assign cmd_valid = (count_r != '0);
  assign cmd       = queue_r[rd_ptr_r];

endmodule

// File: hw/rtl/ssm_back.sv
// ----------------------------------------------------------------------------
// ssm_back
// Executes queued commands: appends elements to the two stores and runs the
// two-pointer merge walk, holding one result back to mark the final one.
// ----------------------------------------------------------------------------
module ssm_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  ssm_pkg::cmd_t cmd,
  output logic          cmd_pop,
  ssm_out_if.source     out_ch
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_RD   = 2'd1;
  localparam logic [1:0] B_CMP  = 2'd2;
  localparam logic [1:0] B_FIN  = 2'd3;

  localparam logic [1:0] ST_BOTH  = 2'd0;
  localparam logic [1:0] ST_TAIL1 = 2'd1;
  localparam logic [1:0] ST_TAIL2 = 2'd2;

  localparam logic [ssm_pkg::LEN_W-1:0] FULL = ssm_pkg::LEN_W'(ssm_pkg::LIST_DEPTH);

  logic [1:0]                   state_r, state_nxt;
  logic [1:0]                   step_r, step_nxt;
  logic [ssm_pkg::MODE_W-1:0]   mode_r, mode_nxt;
  logic [ssm_pkg::LEN_W-1:0]    len1_r, len1_nxt;
  logic [ssm_pkg::LEN_W-1:0]    len2_r, len2_nxt;
  logic                         ovf_r, ovf_nxt;
  logic [ssm_pkg::LEN_W-1:0]    i_r, i_nxt;
  logic [ssm_pkg::LEN_W-1:0]    j_r, j_nxt;
  logic [ssm_pkg::COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic                         pend_v_r, pend_v_nxt;
  ssm_pkg::res_t                pend_r, pend_nxt;
  logic                         out_v_r;
  ssm_pkg::res_t                out_r;

  logic                         we1, we2;
  logic [ssm_pkg::ELEM_W-1:0]   rd1, rd2;
  logic signed [ssm_pkg::ELEM_W-1:0] a, b;
  logic                         out_free;
  logic                         push;
  ssm_pkg::res_t                push_res;
  logic                         gen;
  ssm_pkg::res_t                gen_res;
  logic                         i_lt, j_lt;
  logic                         walk_mode;

  ssm_ram #(.WIDTH(ssm_pkg::ELEM_W), .DEPTH(ssm_pkg::LIST_DEPTH)) u_first_store (
    .clk   (clk),
    .we    (we1),
    .waddr (len1_r[ssm_pkg::ADDR_W-1:0]),
    .wdata (cmd.elem),
    .raddr (i_r[ssm_pkg::ADDR_W-1:0]),
    .rdata (rd1)
  );

  ssm_ram #(.WIDTH(ssm_pkg::ELEM_W), .DEPTH(ssm_pkg::LIST_DEPTH)) u_second_store (
    .clk   (clk),
    .we    (we2),
    .waddr (len2_r[ssm_pkg::ADDR_W-1:0]),
    .wdata (cmd.elem),
    .raddr (j_r[ssm_pkg::ADDR_W-1:0]),
    .rdata (rd2)
  );

  assign a        = $signed(rd1);
  assign b        = $signed(rd2);
  assign out_free = !out_v_r || out_ch.ready;
  assign cmd_pop  = (state_r == B_IDLE) && cmd_valid;
  assign we1      = cmd_pop && cmd.append && !cmd.sel && (len1_r < FULL);
  assign we2      = cmd_pop && cmd.append && cmd.sel && (len2_r < FULL);
  assign i_lt     = (i_r < len1_r);
  assign j_lt     = (j_r < len2_r);
  assign walk_mode = (mode_r == ssm_pkg::MODE_DIFF) || (mode_r == ssm_pkg::MODE_SPLIT) ||
                     (mode_r == ssm_pkg::MODE_UNION);

  always_comb begin
    gen                 = 1'b0;
    gen_res.value       = '0;
    gen_res.kind        = ssm_pkg::KIND_COMMON;
    gen_res.valid_res   = 1'b1;
    gen_res.match_count = '0;
    gen_res.overflow    = ovf_r;
    gen_res.final_res   = 1'b0;
    case (step_r)
      ST_BOTH: begin
        if (a == b) begin
          gen_res.value = a;
          if (mode_r == ssm_pkg::MODE_INTERSECT || mode_r == ssm_pkg::MODE_SPLIT) begin
            gen = 1'b1;
          end else if (mode_r == ssm_pkg::MODE_UNION) begin
            gen          = 1'b1;
            gen_res.kind = ssm_pkg::KIND_UNION;
          end
        end else if (b < a) begin
          gen_res.value = b;
          gen_res.kind  = ssm_pkg::KIND_UNION;
          gen           = (mode_r == ssm_pkg::MODE_UNION);
        end else begin
          gen_res.value = a;
          if (mode_r == ssm_pkg::MODE_DIFF || mode_r == ssm_pkg::MODE_SPLIT) begin
            gen          = 1'b1;
            gen_res.kind = ssm_pkg::KIND_FIRST;
          end else if (mode_r == ssm_pkg::MODE_UNION) begin
            gen          = 1'b1;
            gen_res.kind = ssm_pkg::KIND_UNION;
          end
        end
      end
      ST_TAIL1: begin
        gen           = 1'b1;
        gen_res.value = a;
        gen_res.kind  = (mode_r == ssm_pkg::MODE_UNION) ? ssm_pkg::KIND_UNION
                                                        : ssm_pkg::KIND_FIRST;
      end
      default: begin
        gen           = 1'b1;
        gen_res.value = b;
        gen_res.kind  = ssm_pkg::KIND_UNION;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    mode_nxt   = mode_r;
    len1_nxt   = len1_r;
    len2_nxt   = len2_r;
    ovf_nxt    = ovf_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    cnt_nxt    = cnt_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    push       = 1'b0;
    push_res   = pend_r;

    unique case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          if (cmd.append) begin
            if (cmd.sel) begin
              if (len2_r < FULL) len2_nxt = len2_r + ssm_pkg::LEN_W'(1);
              else ovf_nxt = 1'b1;
            end else begin
              if (len1_r < FULL) len1_nxt = len1_r + ssm_pkg::LEN_W'(1);
              else ovf_nxt = 1'b1;
            end
          end
          if (cmd.merge) begin
            mode_nxt  = cmd.mode;
            i_nxt     = '0;
            j_nxt     = '0;
            cnt_nxt   = '0;
            state_nxt = B_RD;
          end
        end
      end
      B_RD: begin
        if (mode_r > ssm_pkg::MODE_UNION) begin
          state_nxt = B_FIN;
        end else if (i_lt && j_lt) begin
          step_nxt  = ST_BOTH;
          state_nxt = B_CMP;
        end else if (i_lt && walk_mode) begin
          step_nxt  = ST_TAIL1;
          state_nxt = B_CMP;
        end else if (j_lt && (mode_r == ssm_pkg::MODE_UNION)) begin
          step_nxt  = ST_TAIL2;
          state_nxt = B_CMP;
        end else begin
          state_nxt = B_FIN;
        end
      end
      B_CMP: begin
        if (!(gen && pend_v_r && !out_free)) begin
          case (step_r)
            ST_BOTH: begin
              if (a == b) begin
                cnt_nxt = cnt_r + ssm_pkg::COUNT_W'(1);
                i_nxt   = i_r + ssm_pkg::LEN_W'(1);
                j_nxt   = j_r + ssm_pkg::LEN_W'(1);
              end else if (b < a) begin
                j_nxt = j_r + ssm_pkg::LEN_W'(1);
              end else begin
                i_nxt = i_r + ssm_pkg::LEN_W'(1);
              end
            end
            ST_TAIL1: i_nxt = i_r + ssm_pkg::LEN_W'(1);
            default:  j_nxt = j_r + ssm_pkg::LEN_W'(1);
          endcase
          if (gen) begin
            push       = pend_v_r;
            pend_nxt   = gen_res;
            pend_v_nxt = 1'b1;
          end
          state_nxt = B_RD;
        end
      end
      B_FIN: begin
        if (out_free) begin
          push = 1'b1;
          if (pend_v_r) begin
            push_res           = pend_r;
            push_res.final_res = 1'b1;
          end else begin
            push_res.value       = '0;
            push_res.valid_res   = 1'b0;
            push_res.overflow    = ovf_r;
            push_res.final_res   = 1'b1;
            if (mode_r == ssm_pkg::MODE_COUNT) begin
              push_res.kind        = ssm_pkg::KIND_COUNT;
              push_res.match_count = cnt_r;
            end else begin
              push_res.kind        = ssm_pkg::KIND_COMMON;
              push_res.match_count = '0;
            end
          end
          pend_v_nxt = 1'b0;
          len1_nxt   = '0;
          len2_nxt   = '0;
          ovf_nxt    = 1'b0;
          state_nxt  = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      len1_r   <= '0;
      len2_r   <= '0;
      ovf_r    <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      len1_r   <= len1_nxt;
      len2_r   <= len2_nxt;
      ovf_r    <= ovf_nxt;
      pend_v_r <= pend_v_nxt;
      if (push) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    mode_r <= mode_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    cnt_r  <= cnt_nxt;
    pend_r <= pend_nxt;
    if (push) begin
      out_r <= push_res;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.value       = out_r.value;
  assign out_ch.kind        = out_r.kind;
  assign out_ch.valid_res   = out_r.valid_res;
  assign out_ch.match_count = out_r.match_count;
  assign out_ch.overflow    = out_r.overflow;
  assign out_ch.final_res   = out_r.final_res;

endmodule

// File: hw/rtl/sorted_set_merge_engine.sv
// ----------------------------------------------------------------------------
// sorted_set_merge_engine
// Set operations on two ascending integer lists by a two-pointer merge walk.
// ----------------------------------------------------------------------------
// Load items are taken one per cycle into a four-entry command queue while
// it has room; the back end drains one append per cycle into the two
// 32-entry stores while it is idle, so loading runs at one item a cycle
// when no walk is running. An item marked end_of_load starts the walk; each
// step reads both stores, whose memories have a registered read (B_RD
// presents the addresses, B_CMP compares and waits while the output register
// is full), and the walk ends in B_FIN, which flushes the final result.
// During the walk further items queue up until the queue fills. Results
// leave through an output register. No clearing pass is needed after reset.
module sorted_set_merge_engine (
  input  logic      clk,
  input  logic      rst_n,
  ssm_in_if.sink    in_ch,
  ssm_out_if.source out_ch
);

  logic          cmd_valid;
  logic          cmd_pop;
  ssm_pkg::cmd_t cmd;

  ssm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  ssm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );

endmodule
